>>> hdl/three_wire_serial_master_macros.svh
// assertion macros shared by the rtl files
`ifndef THREE_WIRE_SERIAL_MASTER_MACROS_SVH
`define THREE_WIRE_SERIAL_MASTER_MACROS_SVH

// same-cycle implication, checked out of reset
`define TWS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/tws_pkg.sv
`default_nettype none

package tws_pkg;

    localparam int DELAY_WIDTH_DEF = 10;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int SETUP_RESET     = 9;
    localparam int HALF_RESET      = 45;
    localparam int CFG_INDEX_WIDTH = 1;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SETUP = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HALF  = 1'b1;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_OPEN = 2'd1,
        CMD_NEXT = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        op;
        logic [7:0]  tx_byte;
        logic        last;
        logic        hold;
        logic        io_in;
    } tick_t;

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_PRE  = 5'b00010,
        PH_POST = 5'b00100,
        PH_LOW  = 5'b01000,
        PH_HIGH = 5'b10000
    } phase_t;

endpackage

`default_nettype wire

>>> hdl/tws_front.sv
`default_nettype none

module tws_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic          start_req,
    input  wire logic          operation,
    input  wire logic [7:0]    tx_byte,
    input  wire logic          first_byte,
    input  wire logic          last_byte,
    input  wire logic          hold_select,
    input  wire logic          io_in,
    output logic               push,
    output tws_pkg::tick_t     push_item,
    input  wire logic          q_ready
);

    logic           front_valid_reg;
    logic           front_valid_next;
    tws_pkg::tick_t front_item_reg;
    tws_pkg::tick_t front_item_next;
    logic           accept;

    assign push     = front_valid_reg && q_ready;
    assign in_stall = front_valid_reg && !q_ready;
    assign accept   = in_valid && !in_stall;
    assign push_item = front_item_reg;

    // classify the tick by the command it carries
    always_comb
    begin
        front_item_next.op      = operation;
        front_item_next.tx_byte = tx_byte;
        front_item_next.last    = last_byte;
        front_item_next.hold    = hold_select;
        front_item_next.io_in   = io_in;
        priority if (!start_req)
        begin
            front_item_next.kind = tws_pkg::CMD_NONE;
        end
        else if (first_byte)
        begin
            front_item_next.kind = tws_pkg::CMD_OPEN;
        end
        else
        begin
            front_item_next.kind = tws_pkg::CMD_NEXT;
        end
    end

    always_comb
    begin
        priority if (accept)
        begin
            front_valid_next = 1'b1;
        end
        else if (push)
        begin
            front_valid_next = 1'b0;
        end
        else
        begin
            front_valid_next = front_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            front_item_reg <= front_item_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/tws_queue.sv
`default_nettype none

`include "three_wire_serial_master_macros.svh"

module tws_queue #(
    parameter int DEPTH = tws_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire tws_pkg::tick_t  push_item,
    output logic                 q_ready,
    input  wire logic            pop,
    output logic                 q_valid,
    output tws_pkg::tick_t       head_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    tws_pkg::tick_t entry_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg;
    logic [AW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;

    assign q_ready   = (count_reg != FULL_COUNT);
    assign q_valid   = (count_reg != '0);
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    `TWS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= FULL_COUNT, "queue count overflow")
    `TWS_ASSERT_NOW(a_pop_nonempty, pop, count_reg != '0, "pop from empty queue")

endmodule

`default_nettype wire

>>> hdl/tws_back.sv
`default_nettype none

`include "three_wire_serial_master_macros.svh"

module tws_back #(
    parameter int DELAY_WIDTH = tws_pkg::DELAY_WIDTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [tws_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [DELAY_WIDTH-1:0] cfg_data,
    input  wire logic                   q_valid,
    input  wire tws_pkg::tick_t         head_item,
    output logic                        pop,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic                        clk_pin,
    output logic                        select_pin,
    output logic                        io_drive,
    output logic                        io_out,
    output logic [7:0]                  rx_byte,
    output logic                        rx_valid,
    output logic                        byte_done,
    output logic                        busy_res
);

    localparam logic [DELAY_WIDTH-1:0] ONE_TICK = DELAY_WIDTH'(1);

    logic [DELAY_WIDTH-1:0] setup_reg;
    logic [DELAY_WIDTH-1:0] half_reg;

    tws_pkg::phase_t        phase_reg, phase_next;
    logic [DELAY_WIDTH-1:0] count_reg, count_next;
    logic [2:0]             bit_reg, bit_next;
    logic [7:0]             shift_reg, shift_next;
    logic                   write_reg, write_next;
    logic                   closing_reg, closing_next;
    logic                   keep_reg, keep_next;
    logic                   select_reg, select_next;
    logic                   clock_reg, clock_next;
    logic                   drive_reg, drive_next;
    logic                   data_reg, data_next;

    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             rx_byte_reg, rx_byte_next;
    logic                   rx_valid_reg, rx_valid_next;
    logic                   done_reg, done_next;
    logic                   busy_reg, busy_next;

    assign pop = q_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        bit_next      = bit_reg;
        shift_next    = shift_reg;
        write_next    = write_reg;
        closing_next  = closing_reg;
        keep_next     = keep_reg;
        select_next   = select_reg;
        clock_next    = clock_reg;
        drive_next    = drive_reg;
        data_next     = data_reg;
        busy_next     = 1'b0;
        done_next     = 1'b0;
        rx_valid_next = 1'b0;
        rx_byte_next  = 8'd0;
        unique case (phase_reg)
            tws_pkg::PH_PRE:
            begin
                busy_next = 1'b1;
                if (count_reg >= setup_reg)
                begin
                    select_next = 1'b1;
                    drive_next  = write_reg;
                    phase_next  = tws_pkg::PH_POST;
                    count_next  = '0;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            tws_pkg::PH_POST:
            begin
                busy_next = 1'b1;
                if (count_reg >= setup_reg)
                begin
                    clock_next = 1'b0;
                    if (write_reg)
                    begin
                        data_next = shift_reg[bit_reg];
                    end
                    phase_next = tws_pkg::PH_LOW;
                    count_next = ONE_TICK;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            tws_pkg::PH_LOW:
            begin
                busy_next = 1'b1;
                if (count_reg >= half_reg)
                begin
                    if (!write_reg)
                    begin
                        shift_next[bit_reg] = shift_reg[bit_reg] | head_item.io_in;
                    end
                    clock_next = 1'b1;
                    phase_next = tws_pkg::PH_HIGH;
                    count_next = ONE_TICK;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            tws_pkg::PH_HIGH:
            begin
                busy_next = 1'b1;
                if (count_reg >= half_reg)
                begin
                    if (bit_reg == 3'd7)
                    begin
                        done_next = 1'b1;
                        if (!write_reg)
                        begin
                            rx_valid_next = 1'b1;
                            rx_byte_next  = shift_reg;
                        end
                        if (closing_reg && !keep_reg)
                        begin
                            select_next = 1'b0;
                        end
                        phase_next = tws_pkg::PH_IDLE;
                        count_next = '0;
                        bit_next   = 3'd0;
                    end
                    else
                    begin
                        bit_next   = bit_reg + 1'b1;
                        clock_next = 1'b0;
                        if (write_reg)
                        begin
                            data_next = shift_reg[bit_next];
                        end
                        phase_next = tws_pkg::PH_LOW;
                        count_next = ONE_TICK;
                    end
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            default:
            begin
                phase_next = tws_pkg::PH_IDLE;
                if (head_item.kind != tws_pkg::CMD_NONE)
                begin
                    write_next   = head_item.op;
                    shift_next   = head_item.op ? head_item.tx_byte : 8'd0;
                    closing_next = head_item.last;
                    keep_next    = head_item.hold;
                    bit_next     = 3'd0;
                    if (head_item.kind == tws_pkg::CMD_OPEN)
                    begin
                        phase_next = tws_pkg::PH_PRE;
                        count_next = '0;
                        if (setup_reg == '0)
                        begin
                            select_next = 1'b1;
                            drive_next  = head_item.op;
                            phase_next  = tws_pkg::PH_POST;
                        end
                    end
                    else
                    begin
                        clock_next = 1'b0;
                        if (head_item.op)
                        begin
                            data_next = head_item.tx_byte[0];
                        end
                        phase_next = tws_pkg::PH_LOW;
                        count_next = ONE_TICK;
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        priority if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setup_reg <= DELAY_WIDTH'(tws_pkg::SETUP_RESET);
            half_reg  <= DELAY_WIDTH'(tws_pkg::HALF_RESET);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tws_pkg::CFG_SETUP: setup_reg <= cfg_data;
                tws_pkg::CFG_HALF:  half_reg  <= cfg_data;
                default:            setup_reg <= setup_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= tws_pkg::PH_IDLE;
            count_reg     <= '0;
            bit_reg       <= 3'd0;
            shift_reg     <= 8'd0;
            write_reg     <= 1'b0;
            closing_reg   <= 1'b0;
            keep_reg      <= 1'b0;
            select_reg    <= 1'b0;
            clock_reg     <= 1'b1;
            drive_reg     <= 1'b0;
            data_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                phase_reg   <= phase_next;
                count_reg   <= count_next;
                bit_reg     <= bit_next;
                shift_reg   <= shift_next;
                write_reg   <= write_next;
                closing_reg <= closing_next;
                keep_reg    <= keep_next;
                select_reg  <= select_next;
                clock_reg   <= clock_next;
                drive_reg   <= drive_next;
                data_reg    <= data_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rx_byte_reg  <= rx_byte_next;
            rx_valid_reg <= rx_valid_next;
            done_reg     <= done_next;
            busy_reg     <= busy_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign clk_pin    = clock_reg;
    assign select_pin = select_reg;
    assign io_drive   = drive_reg;
    assign io_out     = data_reg;
    assign rx_byte    = rx_byte_reg;
    assign rx_valid   = rx_valid_reg;
    assign byte_done  = done_reg;
    assign busy_res   = busy_reg;

    `TWS_ASSERT_NOW(a_clock_phase, 1'b1, clock_reg == (phase_reg != tws_pkg::PH_LOW), "clock level out of step with phase")
    `TWS_ASSERT_NOW(a_rx_done, out_valid_reg && rx_valid_reg, done_reg && busy_reg, "read byte without completion")
    `TWS_ASSERT_NEXT(a_hold_state, !pop, $stable(phase_reg) && $stable(count_reg), "sequencer moved without an item")

endmodule

`default_nettype wire

>>> hdl/three_wire_serial_master.sv
// channel  | handshake          | payload
// ---------+--------------------+-----------------------------------------------
// in       | in_valid/in_stall  | start_req operation tx_byte first_byte
//          |                    | last_byte hold_select io_in
// out      | out_valid/out_stall| clk_pin select_pin io_drive io_out rx_byte
//          |                    | rx_valid byte_done busy_res
// cfg      | cfg_we             | cfg_index cfg_data
//
// one item in and one item out per cycle when neither side stalls, every tick one step of the sequencer
// the path from input to result runs through the input register, the queue and the result register
// the queue holds QUEUE_DEPTH ticks so either side can stall on its own
// reset puts select low, clock high, data pin as input and setup/half period at 9/45
`default_nettype none

module three_wire_serial_master #(
    parameter int DELAY_WIDTH = tws_pkg::DELAY_WIDTH_DEF,
    parameter int QUEUE_DEPTH = tws_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [tws_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [DELAY_WIDTH-1:0] cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic                   start_req,
    input  wire logic                   operation,
    input  wire logic [7:0]             tx_byte,
    input  wire logic                   first_byte,
    input  wire logic                   last_byte,
    input  wire logic                   hold_select,
    input  wire logic                   io_in,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic                        clk_pin,
    output logic                        select_pin,
    output logic                        io_drive,
    output logic                        io_out,
    output logic [7:0]                  rx_byte,
    output logic                        rx_valid,
    output logic                        byte_done,
    output logic                        busy_res
);

    logic           push;
    tws_pkg::tick_t push_item;
    logic           q_ready;
    logic           pop;
    logic           q_valid;
    tws_pkg::tick_t head_item;

    tws_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .start_req   (start_req),
        .operation   (operation),
        .tx_byte     (tx_byte),
        .first_byte  (first_byte),
        .last_byte   (last_byte),
        .hold_select (hold_select),
        .io_in       (io_in),
        .push        (push),
        .push_item   (push_item),
        .q_ready     (q_ready)
    );

    tws_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .q_ready   (q_ready),
        .pop       (pop),
        .q_valid   (q_valid),
        .head_item (head_item)
    );

    tws_back #(
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_valid    (q_valid),
        .head_item  (head_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .clk_pin    (clk_pin),
        .select_pin (select_pin),
        .io_drive   (io_drive),
        .io_out     (io_out),
        .rx_byte    (rx_byte),
        .rx_valid   (rx_valid),
        .byte_done  (byte_done),
        .busy_res   (busy_res)
    );

endmodule

`default_nettype wire

>>> bench/tb_three_wire_serial_master.sv
`timescale 1ns / 1ps

module tb_three_wire_serial_master;

    localparam int DW = tws_pkg::DELAY_WIDTH_DEF;
    localparam int STALL_LIMIT = 3000;

    typedef struct packed {
        logic       start;
        logic       op;
        logic [7:0] txb;
        logic       first;
        logic       last;
        logic       hold;
        logic       pin;
    } tick_in_t;

    typedef struct packed {
        logic       clk_lvl;
        logic       sel;
        logic       drv;
        logic       dat;
        logic [7:0] rxb;
        logic       rxv;
        logic       done;
        logic       busy;
    } pin_result_t;

    typedef struct packed {
        tws_pkg::phase_t phase;
        logic [DW-1:0]   count;
        logic [2:0]      bit_idx;
        logic [7:0]      shreg;
        logic            is_wr;
        logic            closing;
        logic            keep;
        logic            sel;
        logic            clk_lvl;
        logic            drv;
        logic            dat;
    } seq_state_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_we = 1'b0;
    logic [tws_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = tws_pkg::CFG_SETUP;
    logic [DW-1:0]                       cfg_data = '0;
    logic                                in_valid = 1'b0;
    logic                                in_stall;
    logic                                start_req = 1'b0;
    logic                                operation = 1'b0;
    logic [7:0]                          tx_byte = 8'd0;
    logic                                first_byte = 1'b0;
    logic                                last_byte = 1'b0;
    logic                                hold_select = 1'b0;
    logic                                io_in = 1'b0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic                                clk_pin;
    logic                                select_pin;
    logic                                io_drive;
    logic                                io_out;
    logic [7:0]                          rx_byte;
    logic                                rx_valid;
    logic                                byte_done;
    logic                                busy_res;

    three_wire_serial_master dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .start_req   (start_req),
        .operation   (operation),
        .tx_byte     (tx_byte),
        .first_byte  (first_byte),
        .last_byte   (last_byte),
        .hold_select (hold_select),
        .io_in       (io_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .clk_pin     (clk_pin),
        .select_pin  (select_pin),
        .io_drive    (io_drive),
        .io_out      (io_out),
        .rx_byte     (rx_byte),
        .rx_valid    (rx_valid),
        .byte_done   (byte_done),
        .busy_res    (busy_res)
    );

    logic [DW-1:0] setup_cfg = DW'(tws_pkg::SETUP_RESET);
    logic [DW-1:0] half_cfg = DW'(tws_pkg::HALF_RESET);
    seq_state_t    model_state;
    seq_state_t    plan_state;
    tick_in_t      pending_ticks[$];
    pin_result_t   pin_expect_q[$];
    int            ticks_pushed = 0;
    int            ticks_taken = 0;
    int            results_seen = 0;
    int            errors = 0;
    int            reads_done = 0;
    int            writes_done = 0;
    int            reg_writes = 0;
    int            pin_mode = 0;
    int            send_gap = 0;
    int            stall_left = 0;
    bit            in_steady = 1'b0;
    bit            out_steady = 1'b0;
    bit            in_taken = 1'b0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic seq_state_t idle_state();
        seq_state_t s;
        s = '0;
        s.phase = tws_pkg::PH_IDLE;
        s.clk_lvl = 1'b1;
        return s;
    endfunction

    function automatic bit rbit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic bit [7:0] rbyte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic drop_clock(inout seq_state_t s);
        s.clk_lvl = 1'b0;
        if (s.is_wr)
            s.dat = s.shreg[s.bit_idx];
        s.phase = tws_pkg::PH_LOW;
        s.count = DW'(1);
    endtask

    // one timing tick of the serial sequencer
    task automatic step_sequencer(inout seq_state_t s, input tick_in_t t,
                                  output pin_result_t r);
        r = '0;
        case (s.phase)
            tws_pkg::PH_PRE:
            begin
                r.busy = 1'b1;
                if (s.count >= setup_cfg)
                begin
                    s.sel = 1'b1;
                    s.drv = s.is_wr;
                    s.phase = tws_pkg::PH_POST;
                    s.count = '0;
                end
                else
                    s.count = s.count + 1'b1;
            end
            tws_pkg::PH_POST:
            begin
                r.busy = 1'b1;
                if (s.count >= setup_cfg)
                    drop_clock(s);
                else
                    s.count = s.count + 1'b1;
            end
            tws_pkg::PH_LOW:
            begin
                r.busy = 1'b1;
                if (s.count >= half_cfg)
                begin
                    if (!s.is_wr)
                        s.shreg[s.bit_idx] = s.shreg[s.bit_idx] | t.pin;
                    s.clk_lvl = 1'b1;
                    s.phase = tws_pkg::PH_HIGH;
                    s.count = DW'(1);
                end
                else
                    s.count = s.count + 1'b1;
            end
            tws_pkg::PH_HIGH:
            begin
                r.busy = 1'b1;
                if (s.count >= half_cfg)
                begin
                    if (s.bit_idx == 3'd7)
                    begin
                        r.done = 1'b1;
                        if (!s.is_wr)
                        begin
                            r.rxv = 1'b1;
                            r.rxb = s.shreg;
                        end
                        if (s.closing && !s.keep)
                            s.sel = 1'b0;
                        s.phase = tws_pkg::PH_IDLE;
                        s.count = '0;
                        s.bit_idx = '0;
                    end
                    else
                    begin
                        s.bit_idx = s.bit_idx + 1'b1;
                        drop_clock(s);
                    end
                end
                else
                    s.count = s.count + 1'b1;
            end
            default:
            begin
                s.phase = tws_pkg::PH_IDLE;
                if (t.start)
                begin
                    s.is_wr = t.op;
                    s.shreg = t.op ? t.txb : 8'd0;
                    s.closing = t.last;
                    s.keep = t.hold;
                    s.bit_idx = '0;
                    if (t.first)
                    begin
                        s.phase = tws_pkg::PH_PRE;
                        s.count = '0;
                        if (setup_cfg == '0)
                        begin
                            s.sel = 1'b1;
                            s.drv = s.is_wr;
                            s.phase = tws_pkg::PH_POST;
                        end
                    end
                    else
                        drop_clock(s);
                end
            end
        endcase
        r.clk_lvl = s.clk_lvl;
        r.sel = s.sel;
        r.drv = s.drv;
        r.dat = s.dat;
    endtask

    task automatic flag_error(input string what, input int want, input int seen);
        errors++;
        if (errors <= 40)
            $display("mismatch at result %0d: %s expected %0d got %0d",
                     results_seen, what, want, seen);
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // driver
    always @(negedge clk)
    begin : drive_items
        tick_in_t t;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (send_gap > 0 || pending_ticks.size() == 0)
            begin
                in_valid <= 1'b0;
                if (send_gap > 0)
                    send_gap--;
            end
            else
            begin
                t = pending_ticks.pop_front();
                in_valid <= 1'b1;
                start_req <= t.start;
                operation <= t.op;
                tx_byte <= t.txb;
                first_byte <= t.first;
                last_byte <= t.last;
                hold_select <= t.hold;
                io_in <= t.pin;
                if ($urandom_range(0, 49) == 0)
                    in_steady = !in_steady;
                send_gap = in_steady ? 0 : gap_len();
            end
        end
    end

    always @(negedge clk)
    begin : drive_stall
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            if ($urandom_range(0, 49) == 0)
                out_steady = !out_steady;
            if (rst_n && !out_steady)
                stall_left = gap_len();
        end
    end

    // monitor
    always @(posedge clk)
    begin : watch_ports
        tick_in_t    t;
        pin_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pin_expect_q.size() == 0)
                    flag_error("unexpected item", 0, 1);
                else
                begin
                    want = pin_expect_q.pop_front();
                    if (clk_pin !== want.clk_lvl)
                        flag_error("clk_pin", want.clk_lvl, clk_pin);
                    if (select_pin !== want.sel)
                        flag_error("select_pin", want.sel, select_pin);
                    if (io_drive !== want.drv)
                        flag_error("io_drive", want.drv, io_drive);
                    if (io_out !== want.dat)
                        flag_error("io_out", want.dat, io_out);
                    if (rx_byte !== want.rxb)
                        flag_error("rx_byte", want.rxb, rx_byte);
                    if (rx_valid !== want.rxv)
                        flag_error("rx_valid", want.rxv, rx_valid);
                    if (byte_done !== want.done)
                        flag_error("byte_done", want.done, byte_done);
                    if (busy_res !== want.busy)
                        flag_error("busy_res", want.busy, busy_res);
                    if (want.rxv)
                        reads_done++;
                    else if (want.done)
                        writes_done++;
                end
                results_seen++;
            end
            if (in_valid && !in_stall)
            begin
                t.start = start_req;
                t.op = operation;
                t.txb = tx_byte;
                t.first = first_byte;
                t.last = last_byte;
                t.hold = hold_select;
                t.pin = io_in;
                step_sequencer(model_state, t, want);
                pin_expect_q.push_back(want);
                ticks_taken++;
            end
            in_taken = in_valid && !in_stall;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic add_tick(input bit start, input bit op, input bit [7:0] txb,
                            input bit first, input bit last, input bit hold);
        tick_in_t    t;
        pin_result_t unused;
        t.start = start;
        t.op = op;
        t.txb = txb;
        t.first = first;
        t.last = last;
        t.hold = hold;
        t.pin = (pin_mode == 0) ? rbit() : (pin_mode == 1);
        step_sequencer(plan_state, t, unused);
        pending_ticks.push_back(t);
        ticks_pushed++;
    endtask

    // run out the current byte with ignored commands mixed in
    task automatic settle();
        int n;
        while (plan_state.phase != tws_pkg::PH_IDLE)
            add_tick(rbit(), rbit(), rbyte(), rbit(), rbit(), rbit());
        n = $urandom_range(0, 2);
        repeat (n)
            add_tick(1'b0, rbit(), rbyte(), rbit(), rbit(), rbit());
    endtask

    task automatic send_byte(input bit op, input bit [7:0] txb, input bit first,
                             input bit last, input bit hold);
        settle();
        add_tick(1'b1, op, txb, first, last, hold);
    endtask

    task automatic wait_drained();
        while (ticks_taken != ticks_pushed || pin_expect_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic cfg_write(input logic [tws_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input int value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[DW-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == tws_pkg::CFG_SETUP)
            setup_cfg = value[DW-1:0];
        else
            half_cfg = value[DW-1:0];
        reg_writes++;
    endtask

    task automatic set_timing(input int setup, input int half);
        settle();
        wait_drained();
        repeat (6) @(negedge clk);
        cfg_write(tws_pkg::CFG_SETUP, setup);
        cfg_write(tws_pkg::CFG_HALF, half);
    endtask

    task automatic random_phase(input int n_ticks, input bit pause_midway);
        int stop_at;
        int n;
        bit pause_due;
        stop_at = ticks_pushed + n_ticks;
        pause_due = pause_midway;
        while (ticks_pushed < stop_at)
        begin
            if (pause_due && ticks_pushed >= stop_at - n_ticks / 2)
            begin
                pause_due = 1'b0;
                settle();
                wait_drained();
            end
            if ($urandom_range(0, 4) != 0)
            begin
                n = $urandom_range(1, 3);
                for (int b = 0; b < n; b++)
                    send_byte(rbit(), rbyte(), b == 0, b == n - 1,
                              $urandom_range(0, 3) == 0);
            end
            else
                send_byte(rbit(), rbyte(), rbit(), rbit(), rbit());
        end
        settle();
    endtask

    initial
    begin : stimulus
        model_state = idle_state();
        plan_state = idle_state();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // pin levels out of reset, then one byte with the reset setup wait
        repeat (3)
            add_tick(1'b0, rbit(), rbyte(), rbit(), rbit(), rbit());
        wait_drained();
        repeat (6) @(negedge clk);
        cfg_write(tws_pkg::CFG_HALF, 0);
        send_byte(1'b1, 8'hA5, 1'b1, 1'b1, 1'b0);

        // zero half period, select held across bytes, reads with fixed pin levels
        set_timing(2, 0);
        send_byte(1'b1, 8'h00, 1'b1, 1'b0, 1'b0);
        send_byte(1'b1, 8'hFF, 1'b0, 1'b1, 1'b1);
        pin_mode = 1;
        send_byte(1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
        pin_mode = 2;
        send_byte(1'b0, 8'hFF, 1'b0, 1'b1, 1'b0);
        pin_mode = 0;

        // no setup wait, reopen while still selected
        set_timing(0, 1);
        send_byte(1'b0, 8'h5A, 1'b1, 1'b1, 1'b1);
        send_byte(1'b1, 8'h3C, 1'b1, 1'b0, 1'b0);
        send_byte(1'b1, 8'hC3, 1'b0, 1'b1, 1'b0);

        for (int p = 0; p < 5; p++)
        begin
            set_timing($urandom_range(0, 3), $urandom_range(0, 3));
            random_phase(56, p == 2);
        end
        settle();

        wait_drained();
        repeat (10) @(negedge clk);
        if (pin_expect_q.size() != 0)
            flag_error("items never returned", 0, pin_expect_q.size());
        $display("ran %0d ticks with %0d register writes, setup 0..9 and half 0..3",
                 ticks_taken, reg_writes);
        $display("completed %0d write bytes and %0d read bytes, %0d mismatches",
                 writes_done, reads_done, errors);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/tws_pkg.sv
hdl/tws_front.sv
hdl/tws_queue.sv
hdl/tws_back.sv
hdl/three_wire_serial_master.sv
bench/tb_three_wire_serial_master.sv
